// ===== hw/rtl/prrf_pkg.sv =====
// types and constants shared by the priority reserve ring fifo
// no dependencies
`timescale 1ns / 1ps

package prrf_pkg;

    localparam int ENTRY_BITS        = 64;
    localparam int DROP_COUNTER_BITS = 16;
    localparam int MODE_BITS         = 2;
    localparam int RESERVE_BITS      = 5;
    localparam int OCC_BITS          = 5;

    localparam logic [MODE_BITS-1:0]    MODE_ROUTINE  = 2'd0;
    localparam logic [MODE_BITS-1:0]    MODE_CRITICAL = 2'd1;
    localparam logic [MODE_BITS-1:0]    MODE_POP      = 2'd2;

    localparam logic [RESERVE_BITS-1:0] RESERVE_RESET = 5'd2;

    typedef logic [ENTRY_BITS-1:0]        entry_t;
    typedef logic [DROP_COUNTER_BITS-1:0] drop_t;

    typedef struct packed {
        logic [MODE_BITS-1:0] mode;
        entry_t               entry_data;
    } req_item_t;

    typedef struct packed {
        logic                accepted;
        entry_t              popped_data;
        logic                front_valid;
        entry_t              front_data;
        logic [OCC_BITS-1:0] occupancy;
        drop_t               routine_drop_total;
        drop_t               critical_drop_total;
    } rsp_item_t;

endpackage

// ===== hw/rtl/prrf_slot_ram.sv =====
// slot storage: one write port, one registered read port, write-first on a same-address hit
// depends on prrf_pkg
`timescale 1ns / 1ps

module prrf_slot_ram
    import prrf_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int ADDR_BITS = 4
)
(
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  entry_t               wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output entry_t               rd_data
);

    entry_t slot_mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
    end

    // forward the word being written when it lands on the address being read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= slot_mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/priority_reserve_ring_fifo.sv =====
// priority reserve ring fifo: admission, pointers, drop counters and response register
// depends on prrf_pkg and prrf_slot_ram
`timescale 1ns / 1ps
//
// Usage
//   req channel (req_valid, req_stall, req): one item is a routine push, a critical
//   push or a pop. rsp channel (rsp_valid, rsp_stall, rsp): one result item per
//   request item, in order, with the accept flag, the popped word, the front word,
//   the occupancy and both saturating drop counters after the step.
//   cfg_wr_en / cfg_wr_data write the number of reserved slots; write only while idle.
//   Routine pushes are refused once occupancy plus reserve reaches SLOT_COUNT;
//   critical pushes only when all slots are full. Refused words are dropped.
// Timing
//   A taken item's result is held pending, then enters the response register.
//   One item per cycle is sustained while the receiver does not stall. The front
//   word is read from the slot RAM at the same edge that commits each item, so the
//   RAM's single read port sets that figure.
// Reset
//   Queue empty, drop counters zero, reserve 2. RAM contents are left undefined.
// Stall
//   A stalled result holds in the response register; one more item is taken and
//   held pending, after which req_stall stays high until the result is taken.

module priority_reserve_ring_fifo
    import prrf_pkg::*;
#(
    parameter int SLOT_COUNT = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  req_item_t               req,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output rsp_item_t               rsp,
    input  logic                    cfg_wr_en,
    input  logic [RESERVE_BITS-1:0] cfg_wr_data
);

    localparam int IDX_BITS  = $clog2(SLOT_COUNT);
    localparam int CNT_BITS  = $clog2(SLOT_COUNT + 1);
    localparam int TAIL_BITS = CNT_BITS + 1;
    localparam int SUM_BITS  = ((CNT_BITS > RESERVE_BITS) ? CNT_BITS : RESERVE_BITS) + 1;

    localparam logic [IDX_BITS-1:0]  LAST_IDX   = IDX_BITS'(SLOT_COUNT - 1);
    localparam logic [CNT_BITS-1:0]  FULL_CNT   = CNT_BITS'(SLOT_COUNT);
    localparam logic [TAIL_BITS-1:0] TAIL_WRAP  = TAIL_BITS'(SLOT_COUNT);
    localparam logic [SUM_BITS-1:0]  SLOT_LIMIT = SUM_BITS'(SLOT_COUNT);

    logic [RESERVE_BITS-1:0] reserve_reg;
    logic [IDX_BITS-1:0]     head_reg, head_next;
    logic [CNT_BITS-1:0]     count_reg, count_next;
    drop_t                   routine_drops_reg, routine_drops_next;
    drop_t                   critical_drops_reg, critical_drops_next;
    logic                    pend_reg, pend_next;
    logic                    pend_accepted_reg, pend_accepted_next;
    entry_t                  pend_popped_reg, pend_popped_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_item_t               rsp_reg, rsp_next;

    logic                    req_fire;
    logic                    rsp_free;
    logic                    move_out;
    logic                    is_routine, is_critical, is_pop;
    logic                    routine_full, critical_full, queue_empty;
    logic                    push_ok, pop_ok;
    logic [SUM_BITS-1:0]     routine_sum;
    logic [TAIL_BITS-1:0]    tail_sum;
    logic [IDX_BITS-1:0]     tail_idx;
    entry_t                  ram_rd_data;

    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign move_out  = pend_reg && rsp_free;
    assign req_stall = pend_reg && !rsp_free;
    assign req_fire  = req_valid && !req_stall;

    assign is_routine  = (req.mode == MODE_ROUTINE);
    assign is_critical = (req.mode == MODE_CRITICAL);
    assign is_pop      = (req.mode == MODE_POP);

    assign queue_empty   = (count_reg == '0);
    assign routine_sum   = SUM_BITS'(count_reg) + SUM_BITS'(reserve_reg);
    assign routine_full  = (routine_sum >= SLOT_LIMIT);
    assign critical_full = (count_reg >= FULL_CNT);

    assign push_ok = (is_routine && !routine_full) || (is_critical && !critical_full);
    assign pop_ok  = is_pop && !queue_empty;

    assign tail_sum = TAIL_BITS'(head_reg) + TAIL_BITS'(count_reg);
    assign tail_idx = (tail_sum >= TAIL_WRAP) ? IDX_BITS'(tail_sum - TAIL_WRAP)
                                              : IDX_BITS'(tail_sum);

    always_comb
    begin
        head_next           = head_reg;
        count_next          = count_reg;
        routine_drops_next  = routine_drops_reg;
        critical_drops_next = critical_drops_reg;
        pend_accepted_next  = pend_accepted_reg;
        pend_popped_next    = pend_popped_reg;
        pend_next           = pend_reg;

        if (move_out)
        begin
            pend_next = 1'b0;
        end

        if (req_fire)
        begin
            pend_next          = 1'b1;
            pend_accepted_next = push_ok || pop_ok;
            pend_popped_next   = pop_ok ? ram_rd_data : '0;

            if (push_ok)
            begin
                count_next = count_reg + 1'b1;
            end
            else if (pop_ok)
            begin
                count_next = count_reg - 1'b1;
                head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
            end
            else if (is_routine)
            begin
                if (routine_drops_reg != '1)
                begin
                    routine_drops_next = routine_drops_reg + 1'b1;
                end
            end
            else if (is_critical)
            begin
                if (critical_drops_reg != '1)
                begin
                    critical_drops_next = critical_drops_reg + 1'b1;
                end
            end
        end
    end

    // the RAM read at each commit refreshes the front word for the new head
    prrf_slot_ram #(
        .DEPTH     (SLOT_COUNT),
        .ADDR_BITS (IDX_BITS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (req_fire && push_ok),
        .wr_addr (tail_idx),
        .wr_data (req.entry_data),
        .rd_en   (req_fire),
        .rd_addr (head_next),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        rsp_next                     = rsp_reg;
        rsp_valid_next               = rsp_valid_reg;
        if (move_out)
        begin
            rsp_valid_next               = 1'b1;
            rsp_next.accepted            = pend_accepted_reg;
            rsp_next.popped_data         = pend_popped_reg;
            rsp_next.front_valid         = !queue_empty;
            rsp_next.front_data          = queue_empty ? '0 : ram_rd_data;
            rsp_next.occupancy           = OCC_BITS'(count_reg);
            rsp_next.routine_drop_total  = routine_drops_reg;
            rsp_next.critical_drop_total = critical_drops_reg;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserve_reg        <= RESERVE_RESET;
            head_reg           <= '0;
            count_reg          <= '0;
            routine_drops_reg  <= '0;
            critical_drops_reg <= '0;
            pend_reg           <= 1'b0;
            rsp_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                reserve_reg <= cfg_wr_data;
            end
            head_reg           <= head_next;
            count_reg          <= count_next;
            routine_drops_reg  <= routine_drops_next;
            critical_drops_reg <= critical_drops_next;
            pend_reg           <= pend_next;
            rsp_valid_reg      <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_accepted_reg <= pend_accepted_next;
        pend_popped_reg   <= pend_popped_next;
        rsp_reg           <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // occupancy bound
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("occupancy above slot count");

    // a stored push grows the queue by exactly one
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && push_ok) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push did not advance occupancy");

    // a pop of an empty queue is never reported as accepted
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && is_pop && queue_empty) |=> (pend_reg && !pend_accepted_reg))
        else $error("pop of empty queue accepted");

    // a pending result never sits while the response register is free
    a_pend_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && rsp_free && !req_fire) |=> (!pend_reg && rsp_valid_reg))
        else $error("pending result not moved out");

endmodule
